// ===== design/grpb_pkg.sv =====
// Shared types and constants of the Gaussian radial pixel blend core.
// Used by every module of the block; no dependencies of its own.
package grpb_pkg;

    // Default sizing of the core
    localparam int MAX_DIM_DEF  = 8192;
    localparam int NUM_CH_DEF   = 3;

    // Weight arithmetic
    localparam int DIV_STEPS    = 34;               // 4 integer + 30 fraction quotient bits
    localparam int LN2_STEPS    = 5;                // exponent n lies in 0..17
    localparam int HORNER_TERMS = 12;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [33:0] LN2_Q30 = 34'd744261118;
    localparam logic [16:0] W_ONE   = 17'h1_0000;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_SIGMA       = 3'd0,
        REG_ROI_X_FIRST = 3'd1,
        REG_ROI_X_LAST  = 3'd2,
        REG_ROI_Y_FIRST = 3'd3,
        REG_ROI_Y_LAST  = 3'd4,
        REG_IMG_WIDTH   = 3'd5,
        REG_IMG_HEIGHT  = 3'd6,
        REG_CHAN_COUNT  = 3'd7
    } reg_idx_t;

    // Input request
    typedef struct packed {
        logic [12:0] col;
        logic [12:0] row;
        logic [7:0]  first_ch0;
        logic [7:0]  first_ch1;
        logic [7:0]  first_ch2;
        logic [7:0]  second_ch0;
        logic [7:0]  second_ch1;
        logic [7:0]  second_ch2;
    } in_t;

    // Result
    typedef struct packed {
        logic [7:0] blend_ch0;
        logic [7:0] blend_ch1;
        logic [7:0] blend_ch2;
        logic       in_region;
    } out_t;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [19:0] sigma;
        logic [12:0] x_first;
        logic [12:0] x_last;
        logic [12:0] y_first;
        logic [12:0] y_last;
        logic [13:0] img_width;
        logic [13:0] img_height;
        logic [1:0]  chan_count;
        logic [39:0] sig_sq;
        logic [43:0] sig_sq12;
    } cfg_t;

    // Sideband carried along the weight pipeline
    typedef struct packed {
        logic            in_roi;
        logic [2:0]      ch_en;
        logic            w_one;
        logic            w_zero;
        logic [2:0][7:0] a;
        logic [2:0][7:0] b;
    } side_t;

endpackage

// ===== design/grpb_geom.sv =====
// Front end: region test, distance to centre, squared radius, Q15 numerator.
// Depends on grpb_pkg.
module grpb_geom #(
    parameter int MAX_DIM      = grpb_pkg::MAX_DIM_DEF,
    parameter int NUM_CHANNELS = grpb_pkg::NUM_CH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  grpb_pkg::in_t    in_data,
    input  grpb_pkg::cfg_t   cfg,
    output logic             out_valid,
    output logic [41:0]      num,
    output grpb_pkg::side_t  side
);

    localparam int CMAX = MAX_DIM - 1;

    logic [12:0] half_x, half_y, cx, cy;
    logic [12:0] dx1_next, dy1_next;
    grpb_pkg::side_t side1_next, side3_next, side4_next;
    logic [26:0] d2_next;
    logic [41:0] num_next;

    logic            v1_reg, v2_reg, v3_reg, v4_reg;
    logic [12:0]     dx1_reg, dy1_reg;
    logic [25:0]     sqx_reg, sqy_reg;
    logic [26:0]     d2_reg;
    logic [41:0]     num_reg;
    grpb_pkg::side_t side1_reg, side2_reg, side3_reg, side4_reg;

    // Centre, saturated to the largest coordinate
    always_comb
    begin
        half_x = cfg.img_width[13:1];
        half_y = cfg.img_height[13:1];
        cx = (17'(half_x) > 17'(CMAX)) ? 13'(CMAX) : half_x;
        cy = (17'(half_y) > 17'(CMAX)) ? 13'(CMAX) : half_y;
        dx1_next = (in_data.col >= cx) ? in_data.col - cx : cx - in_data.col;
        dy1_next = (in_data.row >= cy) ? in_data.row - cy : cy - in_data.row;
    end

    // Region test and channel enables
    always_comb
    begin
        side1_next.in_roi = (in_data.col >= cfg.x_first) && (in_data.col <= cfg.x_last)
                         && (in_data.row >= cfg.y_first) && (in_data.row <= cfg.y_last);
        side1_next.w_one  = 1'b0;
        side1_next.w_zero = 1'b0;
        side1_next.a      = {in_data.first_ch2, in_data.first_ch1, in_data.first_ch0};
        side1_next.b      = {in_data.second_ch2, in_data.second_ch1, in_data.second_ch0};
        for (int j = 0; j < 3; j++)
        begin
            side1_next.ch_en[j] = (2'(j) < cfg.chan_count) && (j < NUM_CHANNELS);
        end
    end

    // Radius sum and weight overrides
    always_comb
    begin
        d2_next          = 27'(sqx_reg) + 27'(sqy_reg);
        side3_next       = side2_reg;
        side3_next.w_one = (d2_next == 27'd0);
        num_next         = {d2_reg, 15'd0};
        side4_next       = side3_reg;
        side4_next.w_zero = (cfg.sigma == 20'd0) || (44'(num_next) >= cfg.sig_sq12);
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx1_reg   <= dx1_next;
            dy1_reg   <= dy1_next;
            side1_reg <= side1_next;
            sqx_reg   <= dx1_reg * dx1_reg;
            sqy_reg   <= dy1_reg * dy1_reg;
            side2_reg <= side1_reg;
            d2_reg    <= d2_next;
            side3_reg <= side3_next;
            num_reg   <= num_next;
            side4_reg <= side4_next;
        end
    end

    assign out_valid = v4_reg;
    assign num       = num_reg;
    assign side      = side4_reg;

endmodule

// ===== design/grpb_div.sv =====
// Restoring divider for d2*2^15/sigma^2 in Q30, then reduction by ln 2.
// One quotient bit per stage. Depends on grpb_pkg.
module grpb_div (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  logic [41:0]      num,
    input  logic [39:0]      sig_sq,
    input  grpb_pkg::side_t  side_in,
    output logic             out_valid,
    output logic [29:0]      rem,
    output logic [4:0]       nexp,
    output grpb_pkg::side_t  side_out
);

    localparam int DS = grpb_pkg::DIV_STEPS;
    localparam int LS = grpb_pkg::LN2_STEPS;

    logic [43:0] dvs;

    logic            v_ch [DS+1];
    logic [43:0]     r_ch [DS+1];
    logic [33:0]     q_ch [DS+1];
    grpb_pkg::side_t s_ch [DS+1];

    logic            lv_ch [LS+1];
    logic [33:0]     e_ch  [LS+1];
    logic [4:0]      n_ch  [LS+1];
    grpb_pkg::side_t ls_ch [LS+1];

    // Divisor aligned to the top quotient bit (weight 8)
    assign dvs     = {1'b0, sig_sq, 3'b000};
    assign v_ch[0] = in_valid;
    assign r_ch[0] = 44'(num);
    assign q_ch[0] = 34'd0;
    assign s_ch[0] = side_in;

    // One quotient bit per stage
    for (genvar j = 0; j < DS; j++)
    begin : g_div
        logic            qbit;
        logic [43:0]     rem_next;
        logic            v_reg;
        logic [43:0]     rem_reg;
        logic [33:0]     quo_reg;
        grpb_pkg::side_t side_reg;

        always_comb
        begin
            qbit     = (r_ch[j] >= dvs);
            rem_next = (qbit ? r_ch[j] - dvs : r_ch[j]) << 1;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg <= 1'b0;
            else if (adv)
                v_reg <= v_ch[j];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg  <= rem_next;
                quo_reg  <= {q_ch[j][32:0], qbit};
                side_reg <= s_ch[j];
            end
        end

        assign v_ch[j+1] = v_reg;
        assign r_ch[j+1] = rem_reg;
        assign q_ch[j+1] = quo_reg;
        assign s_ch[j+1] = side_reg;
    end

    assign lv_ch[0] = v_ch[DS];
    assign e_ch[0]  = q_ch[DS];
    assign n_ch[0]  = 5'd0;
    assign ls_ch[0] = s_ch[DS];

    // e = n*ln2 + r, one bit of n per stage
    for (genvar i = 0; i < LS; i++)
    begin : g_ln2
        localparam logic [33:0] LSH = grpb_pkg::LN2_Q30 << (LS - 1 - i);
        logic            ge;
        logic            v_reg;
        logic [33:0]     e_reg;
        logic [4:0]      n_reg;
        grpb_pkg::side_t side_reg;

        assign ge = (e_ch[i] >= LSH);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg <= 1'b0;
            else if (adv)
                v_reg <= lv_ch[i];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                e_reg    <= ge ? e_ch[i] - LSH : e_ch[i];
                n_reg    <= {n_ch[i][3:0], ge};
                side_reg <= ls_ch[i];
            end
        end

        assign lv_ch[i+1] = v_reg;
        assign e_ch[i+1]  = e_reg;
        assign n_ch[i+1]  = n_reg;
        assign ls_ch[i+1] = side_reg;
    end

    assign out_valid = lv_ch[LS];
    assign rem       = e_ch[LS][29:0];
    assign nexp      = n_ch[LS];
    assign side_out  = ls_ch[LS];

endmodule

// ===== design/grpb_exp.sv =====
// exp(-r) by a 12-term Horner chain, three stages a term, then scaling to Q1.16.
// Depends on grpb_pkg.
module grpb_exp (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  logic [29:0]      rem,
    input  logic [4:0]       nexp,
    input  grpb_pkg::side_t  side_in,
    output logic             out_valid,
    output logic [16:0]      weight,
    output grpb_pkg::side_t  side_out
);

    localparam int NT = grpb_pkg::HORNER_TERMS;

    logic            v_ch [NT+1];
    logic [30:0]     p_ch [NT+1];
    logic [29:0]     r_ch [NT+1];
    logic [4:0]      n_ch [NT+1];
    grpb_pkg::side_t s_ch [NT+1];

    logic [31:0] round_sum, scaled;
    logic [16:0] w_next;
    logic            wv_reg;
    logic [16:0]     w_reg;
    grpb_pkg::side_t ws_reg;

    assign v_ch[0] = in_valid;
    assign p_ch[0] = grpb_pkg::ONE_Q30;
    assign r_ch[0] = rem;
    assign n_ch[0] = nexp;
    assign s_ch[0] = side_in;

    // p = 1 - floor(floor(r*p)/k), k from 12 down to 1
    for (genvar i = 0; i < NT; i++)
    begin : g_hor
        localparam int K = NT - i;
        localparam logic [31:0] RECIP = 32'(64'd4294967295 / K);

        logic [60:0] prod_a;
        logic [61:0] prod_b;
        logic [33:0] rem_c;
        logic [29:0] q_c;

        logic            va_reg, vb_reg, vc_reg;
        logic [29:0]     ta_reg, tb_reg, qe_reg;
        logic [30:0]     pc_reg;
        logic [29:0]     ra_reg, rb_reg, rc_reg;
        logic [4:0]      na_reg, nb_reg, nc_reg;
        grpb_pkg::side_t sa_reg, sb_reg, sc_reg;

        // Product, reciprocal estimate, then one correction step
        always_comb
        begin
            prod_a = 61'(r_ch[i]) * 61'(p_ch[i]);
            prod_b = 62'(ta_reg) * 62'(RECIP);
            rem_c  = 34'(tb_reg) - 34'(qe_reg) * 34'(K);
            q_c    = qe_reg + 30'(rem_c >= 34'(K));
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                va_reg <= 1'b0;
                vb_reg <= 1'b0;
                vc_reg <= 1'b0;
            end
            else if (adv)
            begin
                va_reg <= v_ch[i];
                vb_reg <= va_reg;
                vc_reg <= vb_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ta_reg <= prod_a[59:30];
                ra_reg <= r_ch[i];
                na_reg <= n_ch[i];
                sa_reg <= s_ch[i];
                tb_reg <= ta_reg;
                qe_reg <= prod_b[61:32];
                rb_reg <= ra_reg;
                nb_reg <= na_reg;
                sb_reg <= sa_reg;
                pc_reg <= grpb_pkg::ONE_Q30 - 31'(q_c);
                rc_reg <= rb_reg;
                nc_reg <= nb_reg;
                sc_reg <= sb_reg;
            end
        end

        assign v_ch[i+1] = vc_reg;
        assign p_ch[i+1] = pc_reg;
        assign r_ch[i+1] = rc_reg;
        assign n_ch[i+1] = nc_reg;
        assign s_ch[i+1] = sc_reg;
    end

    // Scale by 2^-n with rounding, apply overrides
    always_comb
    begin
        round_sum = 32'(p_ch[NT]) + (32'd1 << (6'd13 + 6'(n_ch[NT])));
        scaled    = round_sum >> (6'd14 + 6'(n_ch[NT]));
        if (s_ch[NT].w_one)
            w_next = grpb_pkg::W_ONE;
        else if (s_ch[NT].w_zero)
            w_next = 17'd0;
        else
            w_next = scaled[16:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wv_reg <= 1'b0;
        else if (adv)
            wv_reg <= v_ch[NT];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_reg  <= w_next;
            ws_reg <= s_ch[NT];
        end
    end

    assign out_valid = wv_reg;
    assign weight    = w_reg;
    assign side_out  = ws_reg;

endmodule

// ===== design/grpb_blend.sv =====
// Per-channel blend w*a + (1-w)*b with w in Q1.16; second stage is the output register.
// Depends on grpb_pkg.
module grpb_blend (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  logic [16:0]      weight,
    input  grpb_pkg::side_t  side_in,
    output logic             out_valid,
    output grpb_pkg::out_t   out_data
);

    logic [16:0]      w_inv;
    logic [2:0][23:0] sum;
    logic [2:0][7:0]  val;
    grpb_pkg::out_t   out_next;

    logic             pv_reg, ov_reg;
    logic [2:0][24:0] pa_reg, pb_reg;
    grpb_pkg::side_t  ps_reg;
    grpb_pkg::out_t   out_reg;

    assign w_inv = grpb_pkg::W_ONE - weight;

    // Sum of products, zero outside region or for unused channels
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            sum[j] = 24'(pa_reg[j] + pb_reg[j]);
            val[j] = (ps_reg.in_roi && ps_reg.ch_en[j]) ? sum[j][23:16] : 8'd0;
        end
        out_next.blend_ch0 = val[0];
        out_next.blend_ch1 = val[1];
        out_next.blend_ch2 = val[2];
        out_next.in_region = ps_reg.in_roi;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            pv_reg <= in_valid;
            ov_reg <= pv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
            begin
                pa_reg[j] <= 25'(weight) * 25'(side_in.a[j]);
                pb_reg[j] <= 25'(w_inv) * 25'(side_in.b[j]);
            end
            ps_reg  <= side_in;
            out_reg <= out_next;
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = out_reg;

endmodule

// ===== design/gaussian_radial_pixel_blend_core.sv =====
// Top level of the Gaussian radial pixel blend core: config registers and pipeline.
// Depends on grpb_pkg, grpb_geom, grpb_div, grpb_exp, grpb_blend.
//
//   channel   signals                          direction  request
//   input     in_valid / in_ready / in_data    in         one pixel (coords, 2x3 samples)
//   output    out_valid / out_ready / out_data out        blended pixel, region flag
//   config    cfg_we / cfg_index / cfg_data    in         one register write, no wait
//
// One pixel a cycle sustained while the output is accepted; 4 front stages, 34 divider
// stages (one quotient bit each), 5 ln2 stages, 36 Horner stages, scaling, 2 blend.
// Reset clears all valid bits and loads register defaults; no clearing pass.
// The whole pipeline advances together; it holds only while a result sits
// unaccepted in the output register, so nothing is dropped or repeated.
module gaussian_radial_pixel_blend_core #(
    parameter int MAX_DIM      = grpb_pkg::MAX_DIM_DEF,
    parameter int NUM_CHANNELS = grpb_pkg::NUM_CH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  grpb_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output grpb_pkg::out_t  out_data,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  logic [19:0]     cfg_data
);

    logic adv;

    logic [19:0] sigma_reg;
    logic [12:0] x_first_reg, x_last_reg, y_first_reg, y_last_reg;
    logic [13:0] width_reg, height_reg;
    logic [1:0]  chan_reg;
    logic [39:0] sq_reg;
    logic [43:0] sq12_reg;
    grpb_pkg::cfg_t cfg;

    logic            g_valid, d_valid, e_valid;
    logic [41:0]     g_num;
    logic [29:0]     d_rem;
    logic [4:0]      d_nexp;
    logic [16:0]     e_weight;
    grpb_pkg::side_t g_side, d_side, e_side;

    // Global advance: move unless the output holds a pending result
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_reg   <= 20'd256;
            x_first_reg <= 13'd0;
            x_last_reg  <= 13'd8191;
            y_first_reg <= 13'd0;
            y_last_reg  <= 13'd8191;
            width_reg   <= 14'd8192;
            height_reg  <= 14'd8192;
            chan_reg    <= 2'd3;
        end
        else if (cfg_we)
        begin
            case (grpb_pkg::reg_idx_t'(cfg_index))
                grpb_pkg::REG_SIGMA:       sigma_reg   <= cfg_data;
                grpb_pkg::REG_ROI_X_FIRST: x_first_reg <= cfg_data[12:0];
                grpb_pkg::REG_ROI_X_LAST:  x_last_reg  <= cfg_data[12:0];
                grpb_pkg::REG_ROI_Y_FIRST: y_first_reg <= cfg_data[12:0];
                grpb_pkg::REG_ROI_Y_LAST:  y_last_reg  <= cfg_data[12:0];
                grpb_pkg::REG_IMG_WIDTH:   width_reg   <= cfg_data[13:0];
                grpb_pkg::REG_IMG_HEIGHT:  height_reg  <= cfg_data[13:0];
                grpb_pkg::REG_CHAN_COUNT:  chan_reg    <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // sigma^2 and 12*sigma^2, settled long before an item reaches the divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_reg   <= 40'd65536;
            sq12_reg <= 44'd786432;
        end
        else
        begin
            sq_reg   <= sigma_reg * sigma_reg;
            sq12_reg <= {sq_reg, 3'b000} + {1'b0, sq_reg, 2'b00};
        end
    end

    always_comb
    begin
        cfg.sigma      = sigma_reg;
        cfg.x_first    = x_first_reg;
        cfg.x_last     = x_last_reg;
        cfg.y_first    = y_first_reg;
        cfg.y_last     = y_last_reg;
        cfg.img_width  = width_reg;
        cfg.img_height = height_reg;
        cfg.chan_count = chan_reg;
        cfg.sig_sq     = sq_reg;
        cfg.sig_sq12   = sq12_reg;
    end

    grpb_geom #(
        .MAX_DIM      (MAX_DIM),
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .cfg       (cfg),
        .out_valid (g_valid),
        .num       (g_num),
        .side      (g_side)
    );

    grpb_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (g_valid),
        .num       (g_num),
        .sig_sq    (sq_reg),
        .side_in   (g_side),
        .out_valid (d_valid),
        .rem       (d_rem),
        .nexp      (d_nexp),
        .side_out  (d_side)
    );

    grpb_exp u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (d_valid),
        .rem       (d_rem),
        .nexp      (d_nexp),
        .side_in   (d_side),
        .out_valid (e_valid),
        .weight    (e_weight),
        .side_out  (e_side)
    );

    grpb_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (e_valid),
        .weight    (e_weight),
        .side_in   (e_side),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule
